// File: sv/ccdf_pkg.sv
// Package for the cycle count decimal formatter.
// Holds widths, line layout helpers and the sequencer state type.
// No dependencies.
`default_nettype none

package ccdf_pkg;

  localparam int CountW     = 32;
  localparam int CharW      = 8;
  localparam int DigitW     = 4;
  localparam int DigitCount = 10;
  localparam int LineLen    = 24;
  localparam int ConvCntW   = $clog2(CountW);
  localparam int PosW       = $clog2(LineLen);

  localparam logic [ConvCntW-1:0] ConvLast  = ConvCntW'(CountW - 1);
  localparam logic [PosW-1:0]     PosLast   = PosW'(LineLen - 1);
  localparam logic [PosW-1:0]     PosTag    = '0;
  localparam logic [CharW-1:0]    AsciiZero = 8'h30;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic clear;
    logic conv;
    logic emit;
  } cell_ctrl_t;

  function automatic logic is_digit_pos(input logic [PosW-1:0] pos);
    return pos inside {PosW'(2), PosW'(4), PosW'(5), PosW'(6), PosW'(8), PosW'(9),
                       PosW'(10), PosW'(12), PosW'(13), PosW'(14)};
  endfunction

  function automatic logic [CharW-1:0] fixed_char(input logic [PosW-1:0] pos);
    logic [CharW-1:0] c;
    case (pos)
      PosW'(1):  c = ":";
      PosW'(3):  c = ",";
      PosW'(7):  c = ",";
      PosW'(11): c = ",";
      PosW'(15): c = " ";
      PosW'(16): c = "c";
      PosW'(17): c = "y";
      PosW'(18): c = "c";
      PosW'(19): c = "l";
      PosW'(20): c = "e";
      PosW'(21): c = "s";
      PosW'(22): c = 8'h0a;
      PosW'(23): c = 8'h0d;
      default:   c = '0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// File: sv/ccdf_in_if.sv
// Input channel: cycle count and tag byte with valid/ready.
// Depends on ccdf_pkg.
`default_nettype none

interface ccdf_in_if import ccdf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CountW-1:0] cycle_count;
  logic [CharW-1:0]  tag_char;

  modport source (output valid, cycle_count, tag_char, input ready);
  modport sink   (input valid, cycle_count, tag_char, output ready);
endinterface

`default_nettype wire

// File: sv/ccdf_out_if.sv
// Output channel: one text byte per transaction and a last-byte flag.
// Depends on ccdf_pkg.
`default_nettype none

interface ccdf_out_if import ccdf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CharW-1:0] text_byte;
  logic             line_end;

  modport source (output valid, text_byte, line_end, input ready);
  modport sink   (input valid, text_byte, line_end, output ready);
endinterface

`default_nettype wire

// File: sv/cycle_count_decimal_formatter.sv
// Top level: formats a 32-bit cycle count as a tagged 24-byte decimal text line.
// Depends on ccdf_pkg, ccdf_in_if, ccdf_out_if and ccdf_bcd_chain.
//
//   port    dir   modport  payload                       per transaction
//   in_i    in    sink     cycle_count[31:0], tag_char   one line request
//   out_o   out   source   text_byte[7:0], line_end      one character
//
// An item is accepted, then shifted one bit per step through the digit cell row
// (double dabble), then sends 24 output bytes at one per cycle when not stalled.
// Digits leave the top cell of the row, so each output byte waits on out_o.ready.
// Reset returns the sequencer to idle; digit and payload registers are not reset.
// in_i.ready is high only while idle.
`default_nettype none

module cycle_count_decimal_formatter import ccdf_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  ccdf_in_if.sink     in_i,
  ccdf_out_if.source  out_o
);

  state_e               state_q, state_d;
  logic [ConvCntW-1:0]  cnt_q, cnt_d;
  logic [PosW-1:0]      pos_q, pos_d;
  logic [CountW-1:0]    bin_q;
  logic [CharW-1:0]     tag_q;
  logic                 load;
  logic                 in_ready;
  logic                 out_valid;
  cell_ctrl_t           ctrl;
  logic [DigitW-1:0]    msd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pos_q   <= pos_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    pos_d     = pos_q;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    load      = 1'b0;
    ctrl      = '{clear: 1'b0, conv: 1'b0, emit: 1'b0};
    case (state_q)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_i.valid) begin
          load       = 1'b1;
          ctrl.clear = 1'b1;
          cnt_d      = '0;
          state_d    = ST_CONVERT;
        end
      end
      ST_CONVERT: begin
        ctrl.conv = 1'b1;
        cnt_d     = cnt_q + ConvCntW'(1);
        if (cnt_q == ConvLast) begin
          pos_d   = '0;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_o.ready) begin
          ctrl.emit = is_digit_pos(pos_q);
          pos_d     = pos_q + PosW'(1);
          if (pos_q == PosLast) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      bin_q <= in_i.cycle_count;
      tag_q <= in_i.tag_char;
    end else if (ctrl.conv) begin
      bin_q <= {bin_q[CountW-2:0], 1'b0};
    end
  end

  ccdf_bcd_chain u_chain (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .bit_i  (bin_q[CountW-1]),
    .msd_o  (msd)
  );

  always_comb begin
    if (pos_q == PosTag) begin
      out_o.text_byte = tag_q;
    end else if (is_digit_pos(pos_q)) begin
      out_o.text_byte = AsciiZero | {{(CharW-DigitW){1'b0}}, msd};
    end else begin
      out_o.text_byte = fixed_char(pos_q);
    end
  end

  assign out_o.line_end = (pos_q == PosLast);
  assign out_o.valid    = out_valid;
  assign in_i.ready     = in_ready;

endmodule

`default_nettype wire

// File: sv/ccdf_bcd_cell.sv
// One decimal digit cell: add-3 and shift during conversion, digit shift on output.
// Depends on ccdf_pkg.
`default_nettype none

module ccdf_bcd_cell import ccdf_pkg::*; (
  input  wire logic              clk_i,
  input  wire cell_ctrl_t        ctrl_i,
  input  wire logic              shift_bit_i,
  input  wire logic [DigitW-1:0] load_digit_i,
  output logic                   carry_o,
  output logic [DigitW-1:0]      digit_o
);

  logic [DigitW-1:0] digit_q, digit_d, adj;

  always_comb begin
    adj = (digit_q >= DigitW'(5)) ? digit_q + DigitW'(3) : digit_q;
    digit_d = digit_q;
    if (ctrl_i.clear) begin
      digit_d = '0;
    end else if (ctrl_i.conv) begin
      digit_d = {adj[DigitW-2:0], shift_bit_i};
    end else if (ctrl_i.emit) begin
      digit_d = load_digit_i;
    end
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end

  assign carry_o = adj[DigitW-1];
  assign digit_o = digit_q;

endmodule

`default_nettype wire

// File: sv/ccdf_bcd_chain.sv
// Row of digit cells, least significant first; bits enter at the bottom,
// digits leave at the top. Depends on ccdf_pkg and ccdf_bcd_cell.
`default_nettype none

module ccdf_bcd_chain import ccdf_pkg::*; (
  input  wire logic         clk_i,
  input  wire cell_ctrl_t   ctrl_i,
  input  wire logic         bit_i,
  output logic [DigitW-1:0] msd_o
);

  logic [DigitCount:0]    carry;
  logic [DigitW-1:0]      digit [DigitCount];
  logic [DigitW-1:0]      feed  [DigitCount];

  assign carry[0] = bit_i;

  for (genvar i = 0; i < DigitCount; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign feed[i] = '0;
    end else begin : g_rest
      assign feed[i] = digit[i-1];
    end

    ccdf_bcd_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl_i),
      .shift_bit_i  (carry[i]),
      .load_digit_i (feed[i]),
      .carry_o      (carry[i+1]),
      .digit_o      (digit[i])
    );
  end

  assign msd_o = digit[DigitCount-1];

endmodule

`default_nettype wire

// File: sv/ccdf_checker.sv
// Port-level checks for the cycle count decimal formatter, bound to the top level.
// Depends on ccdf_pkg.
`default_nettype none

module ccdf_checker import ccdf_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_i,
  input wire logic out_valid_i,
  input wire logic out_ready_i,
  input wire logic line_end_i
);

  logic [PosW-1:0] sent_q;
  logic            out_xfer;

  assign out_xfer = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sent_q <= '0;
    end else if (out_xfer) begin
      sent_q <= line_end_i ? '0 : sent_q + PosW'(1);
    end
  end

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output valid dropped while stalled");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i)
    else $error("input ready while a line is being sent");

  a_line_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (line_end_i == (sent_q == PosLast)))
    else $error("line_end not on the last byte of the line");

  a_line_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && line_end_i |=> !out_valid_i && in_ready_i)
    else $error("not idle after the last byte");

  a_convert_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !out_valid_i && !in_ready_i)
    else $error("output or intake right after accepting a request");

endmodule

bind cycle_count_decimal_formatter ccdf_checker u_ccdf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .line_end_i  (out_o.line_end)
);

`default_nettype wire
